/* rtl/itx_pkg.sv */
// itx_pkg: shared types, opcodes, fault codes and sizes for the i-type execute block
// used by itx_exec and i_type_instruction_execute_top; depends on nothing
package itx_pkg;

	localparam int DEF_MEM_WORDS = 4096;
	localparam int REG_COUNT     = 32;
	localparam int REG_AW        = 5;
	localparam int CFG_AW        = 5;

	localparam logic [5:0] OP_REGIMM = 6'h01;
	localparam logic [5:0] OP_BEQ    = 6'h04;
	localparam logic [5:0] OP_BNE    = 6'h05;
	localparam logic [5:0] OP_BLEZ   = 6'h06;
	localparam logic [5:0] OP_BGTZ   = 6'h07;
	localparam logic [5:0] OP_ADDI   = 6'h08;
	localparam logic [5:0] OP_ADDIU  = 6'h09;
	localparam logic [5:0] OP_SLTI   = 6'h0A;
	localparam logic [5:0] OP_SLTIU  = 6'h0B;
	localparam logic [5:0] OP_ANDI   = 6'h0C;
	localparam logic [5:0] OP_ORI    = 6'h0D;
	localparam logic [5:0] OP_XORI   = 6'h0E;
	localparam logic [5:0] OP_LUI    = 6'h0F;
	localparam logic [5:0] OP_LB     = 6'h20;
	localparam logic [5:0] OP_LH     = 6'h21;
	localparam logic [5:0] OP_LWL    = 6'h22;
	localparam logic [5:0] OP_LW     = 6'h23;
	localparam logic [5:0] OP_LBU    = 6'h24;
	localparam logic [5:0] OP_LHU    = 6'h25;
	localparam logic [5:0] OP_LWR    = 6'h26;
	localparam logic [5:0] OP_SB     = 6'h28;
	localparam logic [5:0] OP_SH     = 6'h29;
	localparam logic [5:0] OP_SW     = 6'h2B;

	localparam logic [4:0] RT_BLTZ   = 5'd0;
	localparam logic [4:0] RT_BGEZ   = 5'd1;
	localparam logic [4:0] RT_BLTZAL = 5'd16;
	localparam logic [4:0] RT_BGEZAL = 5'd17;
	localparam logic [4:0] REG_LINK  = 5'd31;

	localparam logic [2:0] FLT_NONE = 3'd0;
	localparam logic [2:0] FLT_OVF  = 3'd1;
	localparam logic [2:0] FLT_MEM  = 3'd2;
	localparam logic [2:0] FLT_BAD  = 3'd3;
	localparam logic [2:0] FLT_NOTI = 3'd4;

	localparam logic [2:0] CFG_GETC   = 3'd0;
	localparam logic [2:0] CFG_PUTC   = 3'd1;
	localparam logic [2:0] CFG_RLOW   = 3'd2;
	localparam logic [2:0] CFG_RHIGH  = 3'd3;
	localparam logic [2:0] CFG_WLOW   = 3'd4;
	localparam logic [2:0] CFG_WHIGH  = 3'd5;

	typedef struct packed {
		logic [29:0] getc;
		logic [29:0] putc;
		logic [29:0] rlow;
		logic [29:0] rhigh;
		logic [29:0] wlow;
		logic [29:0] whigh;
	} cfg_t;

	typedef struct packed {
		logic [31:0] ins;
		logic [29:0] pc;
		logic [29:0] npc;
		logic [7:0]  cin;
		logic        eof;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] addr;
	} op_t;

	typedef struct packed {
		logic        rf_we;
		logic [4:0]  rf_wa;
		logic [31:0] rf_wd;
		logic        mem_we;
		logic [31:0] mem_wd;
		logic [29:0] npc;
		logic [2:0]  fault;
		logic        taken;
		logic        cvalid;
		logic [7:0]  cout;
	} res_t;

endpackage

/* rtl/i_type_instruction_execute_top.sv */
// i_type_instruction_execute_top: three-step pipeline around register file and data memory
// depends on itx_pkg, itx_ram, itx_exec
//
// usage: one instruction transaction on the input channel (instruction, pcs, character
// input) gives one result transaction (next pc, fault code, character flags).
// step 1 reads rs and rt from two register file ram copies, step 2 forms the byte
// address and reads the data memory word, step 3 executes, writes back register and
// memory and loads the output register. a new instruction can be accepted every cycle
// while in_stall is low. register and memory results of an older instruction are
// forwarded to younger ones, so dependent instructions need no wait. when out_stall is
// high the result holds and the pipeline fills its empty steps, then raises in_stall.
// reset clears the register file through valid bits (no clearing pass) and loads the
// configuration defaults; the data memory is not cleared. the user must write
// configuration over the apb port only while idle; the block does not enforce it.
module i_type_instruction_execute_top import itx_pkg::*; #(
	parameter int MEM_WORDS = DEF_MEM_WORDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       instruction,
	input  logic [29:0]       current_pc,
	input  logic [29:0]       next_pc_in,
	input  logic [7:0]        char_in,
	input  logic              char_eof,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [29:0]       next_pc_out,
	output logic [2:0]        fault_code,
	output logic              char_taken,
	output logic              char_out_valid,
	output logic [7:0]        char_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int MEM_AW = $clog2(MEM_WORDS);

	cfg_t cfg_q;

	// step 1
	logic        s1_vld;
	logic [31:0] ins_s1;
	logic [29:0] pc_s1;
	logic [29:0] npc_s1;
	logic [7:0]  cin_s1;
	logic        eof_s1;
	logic        rsv_s1;
	logic        rtv_s1;
	// step 2
	logic        s2_vld;
	op_t         op_s2;
	logic        mfwd_s2;
	logic [31:0] mfwd_d_s2;

	logic [31:0] rf_rd_a;
	logic [31:0] rf_rd_b;
	logic [31:0] mem_rd;
	logic [31:0] a_fw;
	logic [31:0] b_fw;
	logic [31:0] addr_s1;
	logic [31:0] mem_word;
	res_t        res;

	logic [REG_COUNT-1:0] rf_vld_q;
	logic                 wb_en_q;
	logic [REG_AW-1:0]    wb_addr_q;
	logic [31:0]          wb_data_q;

	logic accept, s1_adv, s2_adv, s1_free, s2_free;
	logic rf_we, mem_we;
	logic cfg_we;

	assign s2_adv  = s2_vld && (!out_valid || !out_stall);
	assign s2_free = !s2_vld || s2_adv;
	assign s1_adv  = s1_vld && s2_free;
	assign s1_free = !s1_vld || s1_adv;
	assign accept  = in_valid && s1_free;
	assign in_stall = !s1_free;

	assign rf_we  = s2_adv && res.rf_we;
	assign mem_we = s2_adv && res.mem_we;

	itx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(res.rf_wa), .wdata(res.rf_wd),
		.re(accept), .raddr(instruction[25:21]), .rdata(rf_rd_a)
	);

	itx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(res.rf_wa), .wdata(res.rf_wd),
		.re(accept), .raddr(instruction[20:16]), .rdata(rf_rd_b)
	);

	itx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(mem_we), .waddr(op_s2.addr[MEM_AW+1:2]), .wdata(res.mem_wd),
		.re(s1_adv), .raddr(addr_s1[MEM_AW+1:2]), .rdata(mem_rd)
	);

	// newest write wins: step 3 now, then the last write, then the ram
	function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] ram,
			input logic vld, input logic we, input logic [4:0] wa, input logic [31:0] wd,
			input logic lwe, input logic [4:0] lwa, input logic [31:0] lwd);
		logic [31:0] v;
		if (r == 5'd0) v = 32'd0;
		else if (we && wa == r) v = wd;
		else if (lwe && lwa == r) v = lwd;
		else if (vld) v = ram;
		else v = 32'd0;
		return v;
	endfunction

	assign a_fw = fwd(ins_s1[25:21], rf_rd_a, rsv_s1, rf_we, res.rf_wa, res.rf_wd,
		wb_en_q, wb_addr_q, wb_data_q);
	assign b_fw = fwd(ins_s1[20:16], rf_rd_b, rtv_s1, rf_we, res.rf_wa, res.rf_wd,
		wb_en_q, wb_addr_q, wb_data_q);
	assign addr_s1 = a_fw + {{16{ins_s1[15]}}, ins_s1[15:0]};

	assign mem_word = mfwd_s2 ? mfwd_d_s2 : mem_rd;

	itx_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.op_in(op_s2), .mem_word(mem_word), .cfg(cfg_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld    <= 1'b0;
			s2_vld    <= 1'b0;
			out_valid <= 1'b0;
			rf_vld_q  <= '0;
			wb_en_q   <= 1'b0;
		end else begin
			if (s1_free) s1_vld <= accept;
			if (s2_free) s2_vld <= s1_adv;
			if (!out_valid || !out_stall) out_valid <= s2_vld;
			if (rf_we) begin
				rf_vld_q[res.rf_wa] <= 1'b1;
				wb_en_q             <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= instruction;
			pc_s1  <= current_pc;
			npc_s1 <= next_pc_in;
			cin_s1 <= char_in;
			eof_s1 <= char_eof;
			rsv_s1 <= rf_vld_q[instruction[25:21]];
			rtv_s1 <= rf_vld_q[instruction[20:16]];
		end
		if (s1_adv) begin
			op_s2.ins  <= ins_s1;
			op_s2.pc   <= pc_s1;
			op_s2.npc  <= npc_s1;
			op_s2.cin  <= cin_s1;
			op_s2.eof  <= eof_s1;
			op_s2.a    <= a_fw;
			op_s2.b    <= b_fw;
			op_s2.addr <= addr_s1;
			// store in step 3 lands in the same edge as this read
			mfwd_s2    <= mem_we && (op_s2.addr[MEM_AW+1:2] == addr_s1[MEM_AW+1:2]);
			mfwd_d_s2  <= res.mem_wd;
		end
		if (rf_we) begin
			wb_addr_q <= res.rf_wa;
			wb_data_q <= res.rf_wd;
		end
		if (s2_adv) begin
			next_pc_out    <= res.npc;
			fault_code     <= res.fault;
			char_taken     <= res.taken;
			char_out_valid <= res.cvalid;
			char_out       <= res.cout;
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.getc  <= 30'd4094;
			cfg_q.putc  <= 30'd4095;
			cfg_q.rlow  <= 30'd0;
			cfg_q.rhigh <= 30'd4095;
			cfg_q.wlow  <= 30'd0;
			cfg_q.whigh <= 30'd4095;
		end else if (cfg_we) begin
			case (paddr[CFG_AW-1:2])
				CFG_GETC:  cfg_q.getc  <= pwdata[29:0];
				CFG_PUTC:  cfg_q.putc  <= pwdata[29:0];
				CFG_RLOW:  cfg_q.rlow  <= pwdata[29:0];
				CFG_RHIGH: cfg_q.rhigh <= pwdata[29:0];
				CFG_WLOW:  cfg_q.wlow  <= pwdata[29:0];
				CFG_WHIGH: cfg_q.whigh <= pwdata[29:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[CFG_AW-1:2])
			CFG_GETC:  prdata = {2'b00, cfg_q.getc};
			CFG_PUTC:  prdata = {2'b00, cfg_q.putc};
			CFG_RLOW:  prdata = {2'b00, cfg_q.rlow};
			CFG_RHIGH: prdata = {2'b00, cfg_q.rhigh};
			CFG_WLOW:  prdata = {2'b00, cfg_q.wlow};
			CFG_WHIGH: prdata = {2'b00, cfg_q.whigh};
			default:   prdata = 32'd0;
		endcase
	end

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> res.rf_wa != 5'd0)
		else $error("write to register zero");

	a_fault_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_adv && res.fault != FLT_NONE) |-> (!res.rf_we && !res.mem_we && !res.cvalid))
		else $error("faulting instruction has side effects");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld && !s1_adv) |=> s1_vld)
		else $error("step 1 instruction lost");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(next_pc_out) && $stable(fault_code)))
		else $error("stalled result changed");

endmodule

/* rtl/itx_ram.sv */
// itx_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module itx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/itx_exec.sv */
// itx_exec: execute stage of the i-type block, decode, alu, branches, load align and store merge
// depends on itx_pkg
module itx_exec import itx_pkg::*; #(
	parameter int MEM_WORDS = DEF_MEM_WORDS
) (
	input  op_t         op_in,
	input  logic [31:0] mem_word,
	input  cfg_t        cfg,
	output res_t        res
);

	always_comb begin
		logic [5:0]  op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [15:0] uimm;
		logic [31:0] simm;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] m;
		logic [31:0] s;
		logic [29:0] w;
		logic [1:0]  off;
		logic [1:0]  need;
		logic        br;
		logic        rd_ok;
		logic        wr_ok;
		logic        is_byte;
		logic        is_half;
		logic [4:0]  sh;
		logic [2:0]  fault;

		op    = op_in.ins[31:26];
		rs    = op_in.ins[25:21];
		rt    = op_in.ins[20:16];
		uimm  = op_in.ins[15:0];
		simm  = {{16{uimm[15]}}, uimm};
		a     = op_in.a;
		b     = op_in.b;
		m     = mem_word;
		s     = a + simm;
		w     = op_in.addr[31:2];
		off   = op_in.addr[1:0];
		br    = 1'b0;
		fault = FLT_NONE;
		sh    = 5'd0;
		rd_ok = (w >= cfg.rlow) && (w <= cfg.rhigh) && (w < 30'(MEM_WORDS));
		wr_ok = (w >= cfg.wlow) && (w <= cfg.whigh) && (w < 30'(MEM_WORDS));
		is_byte = (op == OP_LB) || (op == OP_LBU) || (op == OP_SB);
		is_half = (op == OP_LH) || (op == OP_LHU) || (op == OP_SH);
		need  = is_byte ? 2'd3 : (is_half ? 2'd2 : 2'd0);

		res        = '0;
		res.rf_wa  = rt;

		case (op)
			OP_ADDI: begin
				if ((~(a ^ simm) & (a ^ s)) >> 31 != 32'd0) begin
					fault = FLT_OVF;
				end else begin
					res.rf_we = 1'b1;
					res.rf_wd = s;
				end
			end
			OP_ADDIU: begin
				res.rf_we = 1'b1;
				res.rf_wd = s;
			end
			OP_ANDI: begin
				res.rf_we = 1'b1;
				res.rf_wd = a & {16'd0, uimm};
			end
			OP_ORI: begin
				res.rf_we = 1'b1;
				res.rf_wd = a | {16'd0, uimm};
			end
			OP_XORI: begin
				res.rf_we = 1'b1;
				res.rf_wd = a ^ {16'd0, uimm};
			end
			OP_SLTI: begin
				res.rf_we = 1'b1;
				res.rf_wd = {31'd0, $signed(a) < $signed(simm)};
			end
			OP_SLTIU: begin
				res.rf_we = 1'b1;
				res.rf_wd = {31'd0, a < simm};
			end
			OP_LUI: begin
				if (rs != 5'd0) begin
					fault = FLT_BAD;
				end else begin
					res.rf_we = 1'b1;
					res.rf_wd = {uimm, 16'd0};
				end
			end
			OP_BEQ: br = (a == b);
			OP_BNE: br = (a != b);
			OP_BLEZ: begin
				if (rt != 5'd0) fault = FLT_BAD;
				else br = (a == 32'd0) || a[31];
			end
			OP_BGTZ: begin
				if (rt != 5'd0) fault = FLT_BAD;
				else br = (a != 32'd0) && !a[31];
			end
			OP_REGIMM: begin
				if (rt == RT_BLTZ || rt == RT_BLTZAL) begin
					br = a[31];
				end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
					br = !a[31];
				end else begin
					fault = FLT_BAD;
				end
				// link is written whether or not the branch is taken
				if (fault == FLT_NONE && rt[4]) begin
					res.rf_we = 1'b1;
					res.rf_wa = REG_LINK;
					res.rf_wd = {op_in.pc, 2'b00} + 32'd8;
				end
			end
			OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
				if (w == cfg.getc) begin
					if (off != need) begin
						fault = FLT_MEM;
					end else begin
						res.rf_we = 1'b1;
						res.rf_wd = op_in.eof ? 32'hFFFF_FFFF : {24'd0, op_in.cin};
						res.taken = 1'b1;
					end
				end else if (!rd_ok || (is_half && off[0]) || (op == OP_LW && off != 2'd0)) begin
					fault = FLT_MEM;
				end else begin
					res.rf_we = 1'b1;
					if (is_byte) begin
						sh = {~off, 3'b000};
						res.rf_wd = (m >> sh) & 32'h0000_00FF;
						if (op == OP_LB && res.rf_wd[7]) res.rf_wd[31:8] = '1;
					end else if (is_half) begin
						sh = {~off[1], 4'b0000};
						res.rf_wd = (m >> sh) & 32'h0000_FFFF;
						if (op == OP_LH && res.rf_wd[15]) res.rf_wd[31:16] = '1;
					end else begin
						res.rf_wd = m;
					end
				end
			end
			OP_LWL: begin
				if (!rd_ok) begin
					fault = FLT_MEM;
				end else begin
					res.rf_we = 1'b1;
					sh = {off, 3'b000};
					if (off == 2'd0) res.rf_wd = m;
					else res.rf_wd = (m << sh) | (b & ((32'd1 << sh) - 32'd1));
				end
			end
			OP_LWR: begin
				if (!rd_ok) begin
					fault = FLT_MEM;
				end else begin
					res.rf_we = 1'b1;
					sh = {~off, 3'b000};
					if (off == 2'd3) res.rf_wd = m;
					else res.rf_wd = (m >> sh) | (b & ~(32'hFFFF_FFFF >> sh));
				end
			end
			OP_SB, OP_SH, OP_SW: begin
				if (w == cfg.putc) begin
					if (off != need) begin
						fault = FLT_MEM;
					end else begin
						res.cvalid = 1'b1;
						res.cout   = b[7:0];
					end
				end else if (!wr_ok || (is_half && off[0]) || (op == OP_SW && off != 2'd0)) begin
					fault = FLT_MEM;
				end else begin
					res.mem_we = 1'b1;
					if (is_byte) begin
						sh = {~off, 3'b000};
						res.mem_wd = (m & ~(32'h0000_00FF << sh)) | ({24'd0, b[7:0]} << sh);
					end else if (is_half) begin
						sh = {~off[1], 4'b0000};
						res.mem_wd = (m & ~(32'h0000_FFFF << sh)) | ({16'd0, b[15:0]} << sh);
					end else begin
						res.mem_wd = b;
					end
				end
			end
			default: fault = FLT_NOTI;
		endcase

		if (res.rf_wa == 5'd0) res.rf_we = 1'b0;

		res.fault = fault;
		if (fault != FLT_NONE) begin
			res.rf_we  = 1'b0;
			res.mem_we = 1'b0;
			res.npc    = op_in.npc;
			res.taken  = 1'b0;
			res.cvalid = 1'b0;
			res.cout   = 8'd0;
		end else if (br) begin
			res.npc = op_in.npc + simm[29:0];
		end else begin
			res.npc = op_in.npc + 30'd1;
		end
	end

endmodule

/* tb/i_type_instruction_execute_top_tb.sv */
// i_type_instruction_execute_top_tb: self-checking testbench for the i-type execute block
// depends on itx_pkg and i_type_instruction_execute_top; each expected result is predicted or typed
`timescale 1ns / 1ps

module i_type_instruction_execute_top_tb;
	import itx_pkg::*;

	localparam int MEMW       = DEF_MEM_WORDS;
	localparam int CYCLE_MAX  = 400000;
	localparam int N_RANDOM   = 900;
	localparam int N_PHASES   = 5;
	localparam int DRAIN_WAIT = 8;

	typedef struct packed {
		logic [29:0] npc;
		logic [2:0]  fault;
		logic        taken;
		logic        cvalid;
		logic [7:0]  cout;
	} outcome_t;

	typedef struct packed {
		logic [31:0] ins;
		logic [29:0] pc;
		logic [29:0] npc;
		logic [7:0]  cin;
		logic        eof;
		logic        typed;
		outcome_t    want;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] instruction;
	logic [29:0] current_pc;
	logic [29:0] next_pc_in;
	logic [7:0] char_in;
	logic char_eof;
	logic out_valid;
	logic out_stall;
	logic [29:0] next_pc_out;
	logic [2:0] fault_code;
	logic char_taken;
	logic char_out_valid;
	logic [7:0] char_out;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// shadow of the block's state
	logic [31:0] regs [0:31];
	logic [31:0] mem [0:MEMW-1];
	bit written [0:MEMW-1];
	logic [29:0] cfg_getc, cfg_putc, cfg_rlow, cfg_rhigh, cfg_wlow, cfg_whigh;

	outcome_t expected_q[$];
	row_t directed[$];
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int hold_cycles = 0;
	int n_sent = 0;
	int n_faults = 0;

	i_type_instruction_execute_top DUT (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] mk(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic bit readable(logic [31:0] w);
		return w >= cfg_rlow && w <= cfg_rhigh && w < MEMW;
	endfunction

	function automatic bit writable(logic [31:0] w);
		return w >= cfg_wlow && w <= cfg_whigh && w < MEMW;
	endfunction

	task automatic set_reg(logic [4:0] r, logic [31:0] v);
		if (r != 0)
			regs[r] = v;
	endtask

	// executes one instruction on the shadow state
	task automatic execute_instr(logic [31:0] ins, logic [29:0] pc, logic [29:0] npc,
			logic [7:0] cin, logic eof, output outcome_t res);
		logic [5:0] op;
		logic [4:0] rs, rt;
		logic [31:0] uimm, simm, a, b, addr, w, s, v, m;
		logic [1:0] off, need;
		logic has_cond, cond;
		int sh;
		op = ins[31:26];
		rs = ins[25:21];
		rt = ins[20:16];
		uimm = {16'h0, ins[15:0]};
		simm = {{16{ins[15]}}, ins[15:0]};
		a = regs[rs];
		b = regs[rt];
		addr = a + simm;
		w = addr >> 2;
		off = addr[1:0];
		has_cond = 0;
		cond = 0;
		res = '0;
		case (op)
			OP_ADDI: begin
				s = a + simm;
				if (a[31] == simm[31] && s[31] != a[31])
					res.fault = FLT_OVF;
				else
					set_reg(rt, s);
			end
			OP_ADDIU: set_reg(rt, a + simm);
			OP_ANDI: set_reg(rt, a & uimm);
			OP_ORI: set_reg(rt, a | uimm);
			OP_XORI: set_reg(rt, a ^ uimm);
			OP_SLTI: set_reg(rt, {31'h0, $signed(a) < $signed(simm)});
			OP_SLTIU: set_reg(rt, {31'h0, a < simm});
			OP_LUI: begin
				if (rs != 0)
					res.fault = FLT_BAD;
				else
					set_reg(rt, {ins[15:0], 16'h0});
			end
			OP_BEQ: begin
				has_cond = 1;
				cond = (a == b);
			end
			OP_BNE: begin
				has_cond = 1;
				cond = (a != b);
			end
			OP_BLEZ, OP_BGTZ: begin
				if (rt != 0) begin
					res.fault = FLT_BAD;
				end else begin
					has_cond = 1;
					cond = (a == 0 || a[31]);
					if (op == OP_BGTZ)
						cond = !cond;
				end
			end
			OP_REGIMM: begin
				if (rt == RT_BLTZ || rt == RT_BLTZAL || rt == RT_BGEZ || rt == RT_BGEZAL) begin
					has_cond = 1;
					cond = (rt == RT_BLTZ || rt == RT_BLTZAL) ? a[31] : !a[31];
					if (rt[4])
						set_reg(REG_LINK, {pc, 2'b00} + 32'd8);
				end else begin
					res.fault = FLT_BAD;
				end
			end
			OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
				need = (op == OP_LB || op == OP_LBU) ? 2'd3 :
					((op == OP_LH || op == OP_LHU) ? 2'd2 : 2'd0);
				if (w == cfg_getc) begin
					if (off != need) begin
						res.fault = FLT_MEM;
					end else begin
						set_reg(rt, eof ? 32'hFFFFFFFF : {24'h0, cin});
						res.taken = 1;
					end
				end else if (!readable(w) || ((op == OP_LH || op == OP_LHU) && off[0])
						|| (op == OP_LW && off != 0)) begin
					res.fault = FLT_MEM;
				end else begin
					v = mem[w];
					if (op == OP_LB || op == OP_LBU) begin
						v = (v >> (24 - 8 * off)) & 32'hFF;
						if (op == OP_LB && v[7])
							v |= 32'hFFFFFF00;
					end else if (op == OP_LH || op == OP_LHU) begin
						v = (v >> (16 - 8 * off)) & 32'hFFFF;
						if (op == OP_LH && v[15])
							v |= 32'hFFFF0000;
					end
					set_reg(rt, v);
				end
			end
			OP_LWL, OP_LWR: begin
				if (!readable(w)) begin
					res.fault = FLT_MEM;
				end else begin
					m = mem[w];
					if (op == OP_LWL) begin
						sh = 8 * off;
						set_reg(rt, off == 0 ? m : ((m << sh) | (b & ((32'h1 << sh) - 1))));
					end else begin
						sh = 8 * (3 - off);
						set_reg(rt, off == 3 ? m : ((m >> sh) | (b & ~(32'hFFFFFFFF >> sh))));
					end
				end
			end
			OP_SB, OP_SH, OP_SW: begin
				need = (op == OP_SB) ? 2'd3 : ((op == OP_SH) ? 2'd2 : 2'd0);
				if (w == cfg_putc) begin
					if (off != need) begin
						res.fault = FLT_MEM;
					end else begin
						res.cvalid = 1;
						res.cout = b[7:0];
					end
				end else if (!writable(w) || (op == OP_SH && off[0])
						|| (op == OP_SW && off != 0)) begin
					res.fault = FLT_MEM;
				end else if (op == OP_SB) begin
					sh = 24 - 8 * off;
					mem[w] = (mem[w] & ~(32'hFF << sh)) | ((b & 32'hFF) << sh);
				end else if (op == OP_SH) begin
					sh = 16 - 8 * off;
					mem[w] = (mem[w] & ~(32'hFFFF << sh)) | ((b & 32'hFFFF) << sh);
				end else begin
					mem[w] = b;
					written[w] = 1;
				end
			end
			default: res.fault = FLT_NOTI;
		endcase
		if (res.fault != FLT_NOTI && res.fault != FLT_NONE) begin
			res.npc = npc;
			res.taken = 0;
			res.cvalid = 0;
			res.cout = 0;
		end else if (res.fault == FLT_NOTI) begin
			res.npc = npc;
		end else if (has_cond && cond) begin
			res.npc = npc + simm[29:0];
		end else begin
			res.npc = npc + 30'd1;
		end
	endtask

	// true when the instruction would read (or merge into) a memory word never fully written
	function automatic bit touches_unwritten(logic [31:0] ins);
		logic [5:0] op;
		logic [31:0] addr, w;
		logic [1:0] off;
		op = ins[31:26];
		addr = regs[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
		w = addr >> 2;
		off = addr[1:0];
		if (w >= MEMW)
			return 0;
		case (op)
			OP_LB, OP_LBU: return w != cfg_getc && readable(w) && !written[w];
			OP_LH, OP_LHU: return w != cfg_getc && readable(w) && !off[0] && !written[w];
			OP_LW: return w != cfg_getc && readable(w) && off == 0 && !written[w];
			OP_LWL, OP_LWR: return readable(w) && !written[w];
			OP_SB: return w != cfg_putc && writable(w) && !written[w];
			OP_SH: return w != cfg_putc && writable(w) && !off[0] && !written[w];
			default: return 0;
		endcase
	endfunction

	function automatic logic [29:0] pick_word();
		case ($urandom_range(0, 9))
			0: return cfg_getc;
			1: return cfg_putc;
			2: return 30'(cfg_rlow + $urandom_range(0, 1) - 1);
			3: return 30'(cfg_whigh + $urandom_range(0, 1));
			4: return 30'(30'd4088 + $urandom_range(0, 8));
			5: return 30'($urandom_range(4096, 8191));
			default: return 30'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic logic [31:0] random_instr();
		logic [5:0] alu_ops [8] = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI,
			OP_SLTIU, OP_LUI};
		logic [5:0] br_ops [5] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_REGIMM};
		logic [5:0] mem_ops [12] = '{OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR,
			OP_SB, OP_SH, OP_SW, OP_SW, OP_LW};
		logic [5:0] op;
		logic [4:0] rs, rt;
		logic [31:0] target, diff;
		int kind;
		kind = $urandom_range(0, 99);
		rs = 5'($urandom);
		rt = 5'($urandom);
		if (kind < 30) begin
			op = alu_ops[$urandom_range(0, 7)];
			if (op == OP_LUI && $urandom_range(0, 3) != 0)
				rs = 0;
			return mk(op, rs, rt, 16'($urandom));
		end else if (kind < 48) begin
			op = br_ops[$urandom_range(0, 4)];
			if ((op == OP_BLEZ || op == OP_BGTZ) && $urandom_range(0, 4) != 0)
				rt = 0;
			if (op == OP_REGIMM && $urandom_range(0, 5) != 0)
				rt = 5'($urandom_range(0, 1) | ($urandom_range(0, 1) << 4));
			return mk(op, rs, rt, 16'($urandom));
		end else if (kind < 90) begin
			op = mem_ops[$urandom_range(0, 11)];
			target = {pick_word(), 2'b00};
			if ($urandom_range(0, 3) == 0)
				target += $urandom_range(0, 3);
			else if (op == OP_LB || op == OP_LBU || op == OP_SB)
				target += (target >> 2) == {2'b0, cfg_getc} || (target >> 2) ==
					{2'b0, cfg_putc} ? 3 : $urandom_range(0, 3);
			else if (op == OP_LH || op == OP_LHU || op == OP_SH)
				target += (target >> 2) == {2'b0, cfg_getc} || (target >> 2) ==
					{2'b0, cfg_putc} ? 2 : 2 * $urandom_range(0, 1);
			diff = target - regs[rs];
			if ($signed(diff) < -32768 || $signed(diff) > 32767) begin
				rs = 0;
				diff = target;
			end
			return mk(op, rs, rt, diff[15:0]);
		end
		return $urandom;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report("result with nothing expected", 0, 0);
			end else begin
				e = expected_q.pop_front();
				if (next_pc_out !== e.npc)
					report("next_pc_out", next_pc_out, e.npc);
				if (fault_code !== e.fault)
					report("fault_code", fault_code, e.fault);
				if (char_taken !== e.taken)
					report("char_taken", char_taken, e.taken);
				if (char_out_valid !== e.cvalid)
					report("char_out_valid", char_out_valid, e.cvalid);
				if (char_out !== e.cout)
					report("char_out", char_out, e.cout);
			end
		end
	end

	// receiver stall pattern, with a long hold-off when requested
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			case ((cycles / 97) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= cycles[3];
			endcase
		end
	end

	// offers one transaction and returns at the edge where it is taken
	task automatic send_instr(logic [31:0] ins, logic [29:0] pc, logic [29:0] npc,
			logic [7:0] cin, logic eof, logic typed, outcome_t want);
		outcome_t got;
		@(negedge clk);
		in_valid <= 1'b1;
		instruction <= ins;
		current_pc <= pc;
		next_pc_in <= npc;
		char_in <= cin;
		char_eof <= eof;
		do
			@(posedge clk);
		while (in_stall);
		execute_instr(ins, pc, npc, cin, eof, got);
		expected_q.push_back(typed ? want : got);
		if (got.fault != FLT_NONE)
			n_faults++;
		n_sent++;
	endtask

	task automatic idle(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle(1);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [29:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {2'b0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_GETC: cfg_getc = val;
			CFG_PUTC: cfg_putc = val;
			CFG_RLOW: cfg_rlow = val;
			CFG_RHIGH: cfg_rhigh = val;
			CFG_WLOW: cfg_wlow = val;
			default: cfg_whigh = val;
		endcase
	endtask

	task automatic add_row(logic [31:0] ins, logic [29:0] pc, logic [29:0] npc, logic [7:0] cin,
			logic eof, logic typed, outcome_t want);
		directed.push_back('{ins, pc, npc, cin, eof, typed, want});
	endtask

	initial begin
		logic [29:0] phase_cfg [N_PHASES][6];
		logic [31:0] ins;
		int burst;
		in_valid = 0;
		instruction = 0;
		current_pc = 0;
		next_pc_in = 0;
		char_in = 0;
		char_eof = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		arst_n = 0;
		for (int i = 0; i < 32; i++)
			regs[i] = 0;
		for (int i = 0; i < MEMW; i++) begin
			mem[i] = 0;
			written[i] = 0;
		end
		cfg_getc = 4094;
		cfg_putc = 4095;
		cfg_rlow = 0;
		cfg_rhigh = 4095;
		cfg_wlow = 0;
		cfg_whigh = 4095;

		add_row(mk(6'h00, 0, 0, 0), 0, 30'h3FFFFFFF, 0, 0, 1, '{30'h3FFFFFFF, FLT_NOTI, 0, 0, 0});
		add_row(mk(OP_LUI, 0, 1, 16'h7FFF), 1, 2, 0, 0, 0, '0);
		add_row(mk(OP_ORI, 1, 1, 16'hFFFF), 2, 3, 0, 0, 0, '0);
		add_row(mk(OP_ADDI, 1, 2, 16'h0001), 3, 4, 0, 0, 1, '{4, FLT_OVF, 0, 0, 0});
		add_row(mk(OP_LUI, 3, 4, 16'h0001), 4, 5, 0, 0, 1, '{5, FLT_BAD, 0, 0, 0});
		add_row(mk(OP_BLEZ, 0, 1, 16'h0004), 5, 6, 0, 0, 1, '{6, FLT_BAD, 0, 0, 0});
		add_row(mk(OP_REGIMM, 0, 5'd2, 16'h0004), 6, 7, 0, 0, 1, '{7, FLT_BAD, 0, 0, 0});
		add_row(mk(OP_SW, 0, 1, 16'h0000), 7, 8, 0, 0, 1, '{9, FLT_NONE, 0, 0, 0});
		add_row(mk(OP_SW, 0, 1, 16'h0004), 8, 9, 0, 0, 0, '0);
		add_row(mk(OP_LW, 0, 5, 16'h0000), 9, 10, 0, 0, 0, '0);
		// character input word, normal, at end of file and misaligned
		add_row(mk(OP_LB, 0, 6, 16'd16379), 10, 11, 8'hA5, 0, 1, '{12, FLT_NONE, 1, 0, 0});
		add_row(mk(OP_LBU, 0, 7, 16'd16379), 11, 12, 8'hFF, 1, 1, '{13, FLT_NONE, 1, 0, 0});
		add_row(mk(OP_LB, 0, 6, 16'd16378), 12, 13, 8'h00, 0, 1, '{13, FLT_MEM, 0, 0, 0});
		add_row(mk(OP_SB, 0, 1, 16'd16383), 13, 14, 0, 0, 1, '{15, FLT_NONE, 0, 1, 8'hFF});
		add_row(mk(OP_LH, 0, 7, 16'h0001), 14, 15, 0, 0, 1, '{15, FLT_MEM, 0, 0, 0});
		add_row(mk(OP_SW, 0, 1, 16'd20000), 15, 16, 0, 0, 1, '{16, FLT_MEM, 0, 0, 0});
		add_row(mk(OP_REGIMM, 0, RT_BGEZAL, 16'hFFFF), 30'h3FFFFFFF, 1000, 0, 0, 1,
			'{999, FLT_NONE, 0, 0, 0});
		add_row(mk(OP_REGIMM, 0, RT_BLTZAL, 16'h0005), 17, 1000, 0, 0, 1,
			'{1001, FLT_NONE, 0, 0, 0});
		add_row(mk(OP_LWL, 0, 8, 16'h0001), 18, 19, 0, 0, 0, '0);
		add_row(mk(OP_LWR, 0, 8, 16'h0006), 19, 20, 0, 0, 0, '0);
		add_row(mk(OP_SB, 0, 31, 16'h0002), 20, 21, 0, 0, 0, '0);
		add_row(mk(OP_SH, 0, 31, 16'h0006), 21, 22, 0, 0, 0, '0);
		add_row(mk(OP_LH, 0, 9, 16'h0004), 22, 23, 0, 0, 0, '0);
		add_row(mk(OP_SLTI, 1, 9, 16'h8000), 23, 24, 0, 0, 0, '0);
		add_row(mk(OP_SLTIU, 1, 10, 16'hFFFF), 24, 25, 0, 0, 0, '0);
		add_row(mk(OP_XORI, 1, 11, 16'hFFFF), 25, 26, 0, 0, 0, '0);
		add_row(mk(OP_BEQ, 0, 0, 16'h7FFF), 26, 30'h3FFFFFFF, 0, 0, 1,
			'{30'h00007FFE, FLT_NONE, 0, 0, 0});
		add_row(mk(OP_BGTZ, 1, 0, 16'h8000), 27, 28, 0, 0, 0, '0);

		phase_cfg[0] = '{20, 21, 4, 40, 8, 30};
		phase_cfg[1] = '{30'h3FFFFFFF, 30'h3FFFFFFE, 0, 30'h3FFFFFFF, 0, 30'h3FFFFFFF};
		phase_cfg[2] = '{0, 0, 30'h3FFFFFFF, 0, 4095, 4095};
		phase_cfg[3] = '{30'($urandom_range(0, 40)), 30'($urandom_range(0, 40)),
			30'($urandom_range(0, 10)), 30'($urandom_range(10, 4095)),
			30'($urandom_range(0, 10)), 30'($urandom_range(10, 4095))};
		phase_cfg[4] = '{4094, 4095, 0, 4095, 0, 4095};

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (directed[i])
			send_instr(directed[i].ins, directed[i].pc, directed[i].npc, directed[i].cin,
				directed[i].eof, directed[i].typed, directed[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			// settle every result before touching configuration
			wait_drained();
			for (int r = 0; r < 6; r++)
				apb_write(r[2:0], phase_cfg[p][r]);
			if (p == 1)
				hold_cycles = 300;
			burst = $urandom_range(1, 20);
			for (int k = 0; k < N_RANDOM / N_PHASES; k++) begin
				ins = random_instr();
				for (int t = 0; t < 30 && touches_unwritten(ins); t++)
					ins = random_instr();
				if (touches_unwritten(ins))
					ins[31:26] = OP_ORI;
				send_instr(ins, 30'($urandom), 30'($urandom), 8'($urandom), 1'($urandom),
					0, '0);
				if (--burst == 0) begin
					if (p != 1 || hold_cycles == 0)
						idle($urandom_range(1, 6));
					burst = $urandom_range(1, 20);
				end
			end
		end
		wait_drained();

		$display("ran %0d instructions (%0d faulting) over %0d configuration phases",
			n_sent, n_faults, N_PHASES + 1);
		$display("%0d results checked in %0d cycles", results_seen, cycles);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/itx_pkg.sv
rtl/itx_ram.sv
rtl/itx_exec.sv
rtl/i_type_instruction_execute_top.sv
tb/i_type_instruction_execute_top_tb.sv
